@@ design/rcpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_pkg: shared types and constants
// Word formats and fixed field widths for the ring capture period meter.
// ----------------------------------------------------------------------------
package rcpm_pkg;

	localparam int CAP_W   = 16;
	localparam int DEN_W   = 4;
	localparam int TOTAL_W = 22;

	// counter values at or below this point advance the high counter
	localparam logic [CAP_W-1:0] HALF_RANGE = 16'h7FFF;

	typedef enum logic {
		MODE_CAPTURE = 1'b0,
		MODE_TICK    = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic [CAP_W-1:0] capture_value;
		logic [CAP_W-1:0] counter_value;
	} rcpm_in_t;

	typedef struct packed {
		logic               high_freq;
		logic [CAP_W-1:0]   period_num;
		logic [DEN_W-1:0]   period_den;
		logic [TOTAL_W-1:0] period_total;
		logic               wrap_resolved;
	} rcpm_out_t;

endpackage

@@ design/rcpm_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_ring: capture timestamp ring
// One write port, two registered read ports. Per-entry valid bits make
// unwritten slots read as zero after reset.
// ----------------------------------------------------------------------------
module rcpm_ring
	import rcpm_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [CAP_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [CAP_W-1:0] rd_data_a,
	output logic [CAP_W-1:0] rd_data_b
);

	logic [CAP_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [CAP_W-1:0] data_a_q;
	logic [CAP_W-1:0] data_b_q;
	logic             vld_a_q;
	logic             vld_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= vld_q[rd_addr_a];
				vld_b_q <= vld_q[rd_addr_b];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_a_q <= mem[rd_addr_a];
			data_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = vld_a_q ? data_a_q : '0;
	assign rd_data_b = vld_b_q ? data_b_q : '0;

endmodule

@@ design/rcpm_period.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpm_period: period arithmetic
// Forms the span/count result or the extended single-edge period with
// rollover correction, and the extended capture for the next tick.
// ----------------------------------------------------------------------------
module rcpm_period
	import rcpm_pkg::*;
#(
	parameter int RING_DEPTH = 16,
	parameter int HIGH_MAX   = 63,
	localparam int IW = $clog2(RING_DEPTH),
	localparam int HW = $clog2(HIGH_MAX + 1),
	localparam int XW = CAP_W + HW
) (
	input  logic [CAP_W-1:0] last_lo,
	input  logic [CAP_W-1:0] first_lo,
	input  logic [IW-1:0]    edges,
	input  logic [HW-1:0]    high_cnt,
	input  logic [XW-1:0]    last_cap,
	output rcpm_out_t        res,
	output logic [XW-1:0]    ext
);

	localparam int SW = 33;
	localparam logic [SW-1:0] STEP_ADD = SW'(33'h1_0000);
	localparam logic [SW-1:0] WRAP_ADD = SW'(HIGH_MAX + 1) << CAP_W;

	logic [IW+3:0] den_ext;
	logic          multi;
	logic          below;
	logic          same_hi;
	logic [SW-1:0] addend;
	logic [SW-1:0] total;

	always_comb begin
		ext     = {high_cnt, last_lo};
		multi   = (edges != IW'(1));
		den_ext = {4'b0000, edges - IW'(1)};
		below   = (ext < last_cap);
		same_hi = (ext[XW-1:CAP_W] == last_cap[XW-1:CAP_W]);
		if (!below) begin
			addend = '0;
		end else if (same_hi) begin
			addend = STEP_ADD;
		end else begin
			addend = WRAP_ADD;
		end
		total = SW'(ext) + addend - SW'(last_cap);

		res = '0;
		if (multi) begin
			res.high_freq  = 1'b1;
			res.period_num = last_lo - first_lo;
			res.period_den = den_ext[DEN_W-1:0];
		end else begin
			res.period_total  = total[TOTAL_W-1:0];
			res.wrap_resolved = below;
		end
	end

endmodule

@@ design/ring_capture_period_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_capture_period_meter: reciprocal period meter
// Edge timestamps go into a ring; timer ticks turn them into period results.
// ----------------------------------------------------------------------------
// Takes one input word per clock while in_ready is high. A capture word
// (mode 0) writes its 16-bit timestamp into the next ring slot and yields
// nothing. A tick word (mode 1) counts the edges stored since the previous
// tick (modulo RING_DEPTH). With no new edge it yields nothing; with two or
// more it yields the wrapped 16-bit span from first to last new capture and
// edges-1; with one it yields the 22-bit period since the last capture,
// extended by the high counter, with wrap_resolved set when a rollover
// correction was applied. A tick whose counter_value is at or below 0x7FFF
// then advances the high counter, which wraps after HIGH_MAX. Throughput is
// one word per cycle while in_ready is high. A tick's result passes the ring
// read, registered at its accepting edge (both endpoints at once through two
// read ports), then the output register. in_ready drops only while a result
// waits in the read stage behind an unaccepted output word. No clearing pass
// after reset: per-slot valid bits make untouched slots read as zero.
// ----------------------------------------------------------------------------
module ring_capture_period_meter
	import rcpm_pkg::*;
#(
	parameter int RING_DEPTH = 16,
	parameter int HIGH_MAX   = 63
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rcpm_in_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output rcpm_out_t out_word
);

	localparam int IW = $clog2(RING_DEPTH);
	localparam int HW = $clog2(HIGH_MAX + 1);
	localparam int XW = CAP_W + HW;
	localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
	localparam logic [HW-1:0] HIGH_TOP = HW'(HIGH_MAX);
	localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(RING_DEPTH);

	// index and counter state
	logic [IW-1:0] write_index_q;
	logic [IW-1:0] prev_index_q;
	logic [HW-1:0] high_count_q;
	logic [XW-1:0] last_capture_q;

	// read stage
	logic          s1_valid_q;
	logic [IW-1:0] edges_s1;
	logic [HW-1:0] high_cnt_s1;

	// output register
	logic      out_valid_q;
	rcpm_out_t out_q;

	logic          in_fire;
	logic          is_tick;
	logic          s1_adv;
	logic          s1_load;
	logic [IW-1:0] edges;
	logic [IW:0]   edges_wide;
	logic [IW-1:0] last_addr;
	logic [IW-1:0] next_index;
	logic [HW-1:0] next_high;
	logic [CAP_W-1:0] last_lo;
	logic [CAP_W-1:0] first_lo;
	rcpm_out_t     res;
	logic [XW-1:0] ext;

	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_fire  = in_valid && in_ready;
	assign is_tick  = (in_word.mode == MODE_TICK);

	// edges since the previous tick, modulo the ring depth
	always_comb begin
		if (write_index_q >= prev_index_q) begin
			edges_wide = {1'b0, write_index_q} - {1'b0, prev_index_q};
		end else begin
			edges_wide = {1'b0, write_index_q} + DEPTH_X - {1'b0, prev_index_q};
		end
		edges      = edges_wide[IW-1:0];
		last_addr  = (write_index_q == '0) ? LAST_IDX : write_index_q - IW'(1);
		next_index = (write_index_q == LAST_IDX) ? '0 : write_index_q + IW'(1);
		next_high  = (high_count_q == HIGH_TOP) ? '0 : high_count_q + HW'(1);
	end

	assign s1_load = in_fire && is_tick && (edges != '0);

	rcpm_ring #(
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (in_fire && !is_tick),
		.wr_addr   (write_index_q),
		.wr_data   (in_word.capture_value),
		.rd_en     (s1_load),
		.rd_addr_a (last_addr),
		.rd_addr_b (prev_index_q),
		.rd_data_a (last_lo),
		.rd_data_b (first_lo)
	);

	rcpm_period #(
		.RING_DEPTH(RING_DEPTH),
		.HIGH_MAX  (HIGH_MAX)
	) u_period (
		.last_lo  (last_lo),
		.first_lo (first_lo),
		.edges    (edges_s1),
		.high_cnt (high_cnt_s1),
		.last_cap (last_capture_q),
		.res      (res),
		.ext      (ext)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q  <= '0;
			prev_index_q   <= '0;
			high_count_q   <= '0;
			last_capture_q <= '0;
			s1_valid_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_fire) begin
				if (is_tick) begin
					prev_index_q <= write_index_q;
					if (in_word.counter_value <= HALF_RANGE) begin
						high_count_q <= next_high;
					end
				end else begin
					write_index_q <= next_index;
				end
			end
			if (s1_adv) begin
				s1_valid_q  <= s1_load;
				out_valid_q <= s1_valid_q;
				if (s1_valid_q) begin
					last_capture_q <= ext;
				end
			end else if (in_ready) begin
				s1_valid_q <= s1_load;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s1_load) begin
			edges_s1    <= edges;
			high_cnt_s1 <= high_count_q;
		end
		if (s1_adv && s1_valid_q) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// a result in the read stage must never be overwritten while blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |-> !in_ready)
		else $error("read stage overrun");

	// a blocked read-stage result survives to the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> s1_valid_q)
		else $error("read stage result dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		(high_count_q <= HIGH_TOP))
		else $error("high counter out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(write_index_q <= LAST_IDX) && (prev_index_q <= LAST_IDX))
		else $error("ring index out of range");

endmodule
